[hw/rtl/pts_pkg.sv]
// ----------------------------------------------------------------------------
// pts_pkg
// Shared widths, codes, weights and the slot entry type of the periodic
// task slot timer.
// ----------------------------------------------------------------------------
package pts_pkg;

  localparam int ACTION_W = 2;
  localparam int SLOT_W   = 5;
  localparam int HANDLE_W = 16;
  localparam int DAYS_W   = 6;
  localparam int HMS_W    = 8;
  localparam int MILLIS_W = 16;
  localparam int TIME_W   = 32;
  localparam int STATUS_W = 3;
  localparam int ACC_W    = 33;
  localparam int WGT_W    = 27;
  localparam int CNT_W    = 5;

  localparam logic [ACTION_W-1:0] ACT_CREATE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_SET    = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_SCAN   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_DONE    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DUE     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTHING = 3'd4;

  localparam logic [SLOT_W-1:0] NO_SLOT     = 5'd16;
  localparam logic [CNT_W-1:0]  MAX_RESULTS = 5'd16;

  localparam logic [WGT_W-1:0] MS_PER_DAY  = 27'd86400000;
  localparam logic [WGT_W-1:0] MS_PER_HOUR = 27'd3600000;
  localparam logic [WGT_W-1:0] MS_PER_MIN  = 27'd60000;
  localparam logic [WGT_W-1:0] MS_PER_SEC  = 27'd1000;
  localparam logic [WGT_W-1:0] MS_PER_MS   = 27'd1;

  localparam logic [TIME_W-1:0] DELAY_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [TIME_W-1:0]   delay;
    logic [TIME_W-1:0]   stamp;
  } slot_entry_t;

endpackage

[hw/rtl/pts_if.sv]
// ----------------------------------------------------------------------------
// pts_if
// Valid/ready channels of the periodic task slot timer: the request channel
// and the result channel.
// ----------------------------------------------------------------------------
interface pts_in_if import pts_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [SLOT_W-1:0]   slot;
  logic [HANDLE_W-1:0] task_handle;
  logic [DAYS_W-1:0]   delay_days;
  logic [HMS_W-1:0]    delay_hours;
  logic [HMS_W-1:0]    delay_minutes;
  logic [HMS_W-1:0]    delay_seconds;
  logic [MILLIS_W-1:0] delay_millis;
  logic [TIME_W-1:0]   now_ms;

  modport source (
    output valid, action, slot, task_handle, delay_days, delay_hours,
           delay_minutes, delay_seconds, delay_millis, now_ms,
    input  ready
  );
  modport sink (
    input  valid, action, slot, task_handle, delay_days, delay_hours,
           delay_minutes, delay_seconds, delay_millis, now_ms,
    output ready
  );
endinterface

interface pts_out_if import pts_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot_out;
  logic [HANDLE_W-1:0] handle_out;
  logic                last;

  modport source (output valid, status, slot_out, handle_out, last, input ready);
  modport sink (input valid, status, slot_out, handle_out, last, output ready);
endinterface

[hw/rtl/periodic_task_slot_timer.sv]
// ----------------------------------------------------------------------------
// periodic_task_slot_timer
// Table of periodic task slots with create, delete, set-delay and scan.
// ----------------------------------------------------------------------------
// Requests arrive on in_ch and results leave on out_ch, both valid/ready;
// a transaction completes when valid and ready are high at a clock edge.
// Every request gives one or more results; last marks the final one.
// Slot entries (handle, delay, stamp) live in one RAM with a registered
// read; occupancy is held in flip-flops. Delete sets its result on
// acceptance. Set-delay folds the delay one weighted term per cycle
// through a single multiplier and then rewrites the entry. Create folds
// the same way and then walks the table one slot per cycle. Scan walks
// one slot per cycle when the result channel keeps up; the single read
// port paces the walk. Due results are held in a result register so that
// last can be set on the final one.
// A new request is taken only when the previous one has delivered its
// final result into the output register. If the receiver stalls, the
// walk halts on the next due slot until the output register frees up.
// Reset clears all occupancy; no RAM clearing pass is needed.
// ----------------------------------------------------------------------------
module periodic_task_slot_timer import pts_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  pts_in_if.sink       in_ch,
  pts_out_if.source    out_ch
);

  localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(SLOTS - 1);
  localparam logic [SLOT_W:0] SLOTS_EXT = (SLOT_W + 1)'(SLOTS);
  localparam logic [2:0] K_LAST = 3'd4;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FOLD = 3'd1;
  localparam logic [2:0] S_WALK = 3'd2;
  localparam logic [2:0] S_SDW  = 3'd3;
  localparam logic [2:0] S_SCAN = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]          state_r, state_nxt;
  logic [SLOTS-1:0]    occ_r, occ_nxt;
  logic [2:0]          k_r, k_nxt;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic [IDXW-1:0]     idx_r, idx_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                res_valid_r, res_valid_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [SLOT_W-1:0]   res_slot_r, res_slot_nxt;
  logic [HANDLE_W-1:0] res_handle_r, res_handle_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]   out_slot_r, out_slot_nxt;
  logic [HANDLE_W-1:0] out_handle_r, out_handle_nxt;
  logic                out_last_r, out_last_nxt;

  logic [ACTION_W-1:0] act_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [HANDLE_W-1:0] handle_r;
  logic [DAYS_W-1:0]   days_r;
  logic [HMS_W-1:0]    hours_r;
  logic [HMS_W-1:0]    minutes_r;
  logic [HMS_W-1:0]    seconds_r;
  logic [MILLIS_W-1:0] millis_r;
  logic [TIME_W-1:0]   now_r;

  logic                accept;
  logic                can_emit;
  logic                in_slot_ok;
  logic                slot_ok;
  logic [IDXW-1:0]     slot_idx;
  logic [IDXW-1:0]     idx_inc;
  logic [CNT_W-1:0]    cnt_inc;
  logic [MILLIS_W-1:0] fld;
  logic [WGT_W-1:0]    wgt;
  logic [MILLIS_W+WGT_W-1:0] prod;
  logic [TIME_W-1:0]   fold_delay;
  logic [TIME_W-1:0]   elapsed;
  logic                due;
  logic                dup;

  logic                ram_we;
  logic [IDXW-1:0]     ram_waddr;
  logic [IDXW-1:0]     ram_raddr;
  slot_entry_t         wr_ent;
  slot_entry_t         rd_ent;
  logic [$bits(slot_entry_t)-1:0] ram_rdata;

  pts_ram #(
    .WIDTH ($bits(slot_entry_t)),
    .DEPTH (SLOTS)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_ent),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_ent = ram_rdata;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign can_emit    = !out_valid_r || out_ch.ready;
  assign in_slot_ok  = {1'b0, in_ch.slot} < SLOTS_EXT;
  assign slot_ok     = {1'b0, slot_r} < SLOTS_EXT;
  assign slot_idx    = slot_r[IDXW-1:0];
  assign idx_inc     = idx_r + 1'b1;
  assign cnt_inc     = cnt_r + 1'b1;

  always_comb begin
    case (k_r)
      3'd0: begin
        fld = MILLIS_W'(days_r);
        wgt = MS_PER_DAY;
      end
      3'd1: begin
        fld = MILLIS_W'(hours_r);
        wgt = MS_PER_HOUR;
      end
      3'd2: begin
        fld = MILLIS_W'(minutes_r);
        wgt = MS_PER_MIN;
      end
      3'd3: begin
        fld = MILLIS_W'(seconds_r);
        wgt = MS_PER_SEC;
      end
      3'd4: begin
        fld = millis_r;
        wgt = MS_PER_MS;
      end
      default: begin
        fld = '0;
        wgt = '0;
      end
    endcase
  end

  assign prod       = (MILLIS_W + WGT_W)'(fld) * (MILLIS_W + WGT_W)'(wgt);
  assign fold_delay = acc_r[ACC_W-1] ? DELAY_MAX : acc_r[TIME_W-1:0];
  assign elapsed    = now_r - rd_ent.stamp;
  assign due        = occ_r[idx_r] && (elapsed >= rd_ent.delay);
  assign dup        = occ_r[idx_r] && (handle_r != '0) && (rd_ent.handle == handle_r);

  always_comb begin
    state_nxt      = state_r;
    occ_nxt        = occ_r;
    k_nxt          = k_r;
    acc_nxt        = acc_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    res_valid_nxt  = res_valid_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_handle_nxt = res_handle_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_handle_nxt = out_handle_r;
    out_last_nxt   = out_last_r;
    ram_we         = 1'b0;
    ram_waddr      = idx_r;
    ram_raddr      = '0;
    wr_ent         = rd_ent;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          k_nxt         = '0;
          acc_nxt       = '0;
          idx_nxt       = '0;
          cnt_nxt       = '0;
          res_valid_nxt = 1'b0;
          unique case (in_ch.action) inside
            ACT_CREATE, ACT_SET: begin
              state_nxt = S_FOLD;
            end
            ACT_DELETE: begin
              res_valid_nxt  = 1'b1;
              res_handle_nxt = '0;
              if (in_slot_ok) begin
                occ_nxt[in_ch.slot[IDXW-1:0]] = 1'b0;
                res_status_nxt = ST_DONE;
                res_slot_nxt   = in_ch.slot;
              end else begin
                res_status_nxt = ST_INVALID;
                res_slot_nxt   = NO_SLOT;
              end
              state_nxt = S_FIN;
            end
            ACT_SCAN: begin
              state_nxt = S_SCAN;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_FOLD: begin
        ram_raddr = (act_r == ACT_CREATE) ? '0 : slot_idx;
        acc_nxt   = acc_r + prod[ACC_W-1:0];
        k_nxt     = k_r + 1'b1;
        if (k_r == K_LAST) begin
          if (act_r == ACT_CREATE) begin
            state_nxt = S_WALK;
          end else if (slot_ok) begin
            state_nxt = S_SDW;
          end else begin
            res_valid_nxt  = 1'b1;
            res_status_nxt = ST_INVALID;
            res_slot_nxt   = NO_SLOT;
            res_handle_nxt = '0;
            state_nxt      = S_FIN;
          end
        end
      end

      S_WALK: begin
        ram_raddr = idx_inc;
        if (dup) begin
          res_valid_nxt  = 1'b1;
          res_status_nxt = ST_DONE;
          res_slot_nxt   = SLOT_W'(idx_r);
          res_handle_nxt = handle_r;
          state_nxt      = S_FIN;
        end else if (!occ_r[idx_r]) begin
          ram_we         = 1'b1;
          wr_ent.handle  = handle_r;
          wr_ent.delay   = fold_delay;
          wr_ent.stamp   = now_r;
          occ_nxt[idx_r] = 1'b1;
          res_valid_nxt  = 1'b1;
          res_status_nxt = ST_DONE;
          res_slot_nxt   = SLOT_W'(idx_r);
          res_handle_nxt = handle_r;
          state_nxt      = S_FIN;
        end else if (idx_r == LAST_IDX) begin
          res_valid_nxt  = 1'b1;
          res_status_nxt = ST_FULL;
          res_slot_nxt   = NO_SLOT;
          res_handle_nxt = '0;
          state_nxt      = S_FIN;
        end else begin
          idx_nxt = idx_inc;
        end
      end

      S_SDW: begin
        ram_raddr      = slot_idx;
        ram_we         = 1'b1;
        ram_waddr      = slot_idx;
        wr_ent.delay   = fold_delay;
        res_valid_nxt  = 1'b1;
        res_status_nxt = ST_DONE;
        res_slot_nxt   = slot_r;
        res_handle_nxt = '0;
        state_nxt      = S_FIN;
      end

      S_SCAN: begin
        ram_raddr = idx_inc;
        if (due) begin
          if (res_valid_r && !can_emit) begin
            ram_raddr = idx_r;
          end else begin
            if (res_valid_r) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = res_status_r;
              out_slot_nxt   = res_slot_r;
              out_handle_nxt = res_handle_r;
              out_last_nxt   = 1'b0;
            end
            ram_we         = 1'b1;
            wr_ent.stamp   = now_r;
            res_valid_nxt  = 1'b1;
            res_status_nxt = ST_DUE;
            res_slot_nxt   = SLOT_W'(idx_r);
            res_handle_nxt = rd_ent.handle;
            cnt_nxt        = cnt_inc;
            if ((cnt_inc == MAX_RESULTS) || (idx_r == LAST_IDX)) begin
              state_nxt = S_FIN;
            end else begin
              idx_nxt = idx_inc;
            end
          end
        end else if (idx_r == LAST_IDX) begin
          state_nxt = S_FIN;
        end else begin
          idx_nxt = idx_inc;
        end
      end

      S_FIN: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          if (res_valid_r) begin
            out_status_nxt = res_status_r;
            out_slot_nxt   = res_slot_r;
            out_handle_nxt = res_handle_r;
          end else begin
            out_status_nxt = ST_NOTHING;
            out_slot_nxt   = NO_SLOT;
            out_handle_nxt = '0;
          end
          res_valid_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      res_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      idx_r       <= '0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      res_valid_r <= res_valid_nxt;
      out_valid_r <= out_valid_nxt;
      k_r         <= k_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r        <= acc_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_handle_r <= res_handle_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_handle_r <= out_handle_nxt;
    out_last_r   <= out_last_nxt;
    if (accept) begin
      act_r     <= in_ch.action;
      slot_r    <= in_ch.slot;
      handle_r  <= in_ch.task_handle;
      days_r    <= in_ch.delay_days;
      hours_r   <= in_ch.delay_hours;
      minutes_r <= in_ch.delay_minutes;
      seconds_r <= in_ch.delay_seconds;
      millis_r  <= in_ch.delay_millis;
      now_r     <= in_ch.now_ms;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.slot_out   = out_slot_r;
  assign out_ch.handle_out = out_handle_r;
  assign out_ch.last       = out_last_r;

  // An accepted request always leaves the idle state on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != S_IDLE))
    else $error("request accepted but block stayed idle");

  // No held result may survive into the idle state.
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !res_valid_r)
    else $error("pending result left behind in idle");

  // A scan never produces more than the result limit.
  a_scan_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_RESULTS)
    else $error("scan result count above limit");

  // A due result always names a real slot.
  a_due_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == ST_DUE)) |-> ({1'b0, out_slot_r} < SLOTS_EXT))
    else $error("due result with slot outside the table");

endmodule

[hw/rtl/pts_ram.sv]
// ----------------------------------------------------------------------------
// pts_ram
// Generic single-clock RAM with one write port and one registered read port.
// A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
module pts_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[sim/periodic_task_slot_timer_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_task_slot_timer_tb
// This bench drives create, delete, set-delay and scan requests into the slot
// timer. It starts with a table of directed requests and then sends random
// request streams. The sender works in bursts and the receiver stalls on a
// pattern. Every result transaction is checked against a shadow copy of the
// slot table or, for directed rows that give one, against the expected result.
// ----------------------------------------------------------------------------
module periodic_task_slot_timer_tb;
  import pts_pkg::*;

  localparam int SLOTS          = 16;
  localparam int HALF_PERIOD    = 6;
  localparam int RESET_CYCLES   = 9;
  localparam int RANDOM_ITEMS   = 150;
  localparam int DRAIN_CYCLES   = 3 * SLOTS;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [SLOT_W-1:0]   slot;
    logic [HANDLE_W-1:0] task_handle;
    logic [DAYS_W-1:0]   delay_days;
    logic [HMS_W-1:0]    delay_hours;
    logic [HMS_W-1:0]    delay_minutes;
    logic [HMS_W-1:0]    delay_seconds;
    logic [MILLIS_W-1:0] delay_millis;
    logic [TIME_W-1:0]   now_ms;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_out;
    logic [HANDLE_W-1:0] handle_out;
    logic                last;
  } report_t;

  typedef struct packed {
    request_t req;
    bit       typed;
    report_t  exp;
  } dir_row_t;

  logic clk;
  logic rst_n;

  pts_in_if  in_ch ();
  pts_out_if out_ch ();

  periodic_task_slot_timer #(
    .SLOTS(SLOTS)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic [SLOTS-1:0]    occ_tab;
  logic [TIME_W-1:0]   delay_tab  [SLOTS];
  logic [TIME_W-1:0]   stamp_tab  [SLOTS];
  logic [HANDLE_W-1:0] handle_tab [SLOTS];

  report_t     report_q [$];
  int          error_count;
  int          idle_cycles;
  int          burst_left;
  logic [31:0] sim_now;

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  function automatic logic [TIME_W-1:0] fold_ms(input request_t r);
    logic [63:0] total;
    total = 64'(r.delay_days) * 64'(MS_PER_DAY)
          + 64'(r.delay_hours) * 64'(MS_PER_HOUR)
          + 64'(r.delay_minutes) * 64'(MS_PER_MIN)
          + 64'(r.delay_seconds) * 64'(MS_PER_SEC)
          + 64'(r.delay_millis);
    if (total > 64'(DELAY_MAX)) begin
      total = 64'(DELAY_MAX);
    end
    return total[TIME_W-1:0];
  endfunction

  function automatic void table_apply(input request_t r, output report_t res[$]);
    int          i;
    bit          hit;
    logic [31:0] elapsed;
    res = {};
    hit = 1'b0;
    case (r.action)
      ACT_CREATE: begin
        for (i = 0; i < SLOTS; i++) begin
          if (r.task_handle != '0 && handle_tab[i] == r.task_handle) begin
            hit = 1'b1;
            break;
          end
          if (!occ_tab[i]) begin
            handle_tab[i] = r.task_handle;
            delay_tab[i]  = fold_ms(r);
            stamp_tab[i]  = r.now_ms;
            occ_tab[i]    = 1'b1;
            hit           = 1'b1;
            break;
          end
        end
        if (hit) begin
          res.push_back('{ST_DONE, SLOT_W'(i), r.task_handle, 1'b0});
        end else begin
          res.push_back('{ST_FULL, NO_SLOT, '0, 1'b0});
        end
      end
      ACT_DELETE, ACT_SET: begin
        if (r.slot >= SLOTS) begin
          res.push_back('{ST_INVALID, NO_SLOT, '0, 1'b0});
        end else begin
          if (r.action == ACT_DELETE) begin
            occ_tab[r.slot]    = 1'b0;
            delay_tab[r.slot]  = '0;
            stamp_tab[r.slot]  = '0;
            handle_tab[r.slot] = '0;
          end else begin
            delay_tab[r.slot] = fold_ms(r);
          end
          res.push_back('{ST_DONE, r.slot, '0, 1'b0});
        end
      end
      default: begin
        for (i = 0; i < SLOTS && res.size() < int'(MAX_RESULTS); i++) begin
          elapsed = r.now_ms - stamp_tab[i];
          if (occ_tab[i] && elapsed >= delay_tab[i]) begin
            stamp_tab[i] = r.now_ms;
            res.push_back('{ST_DUE, SLOT_W'(i), handle_tab[i], 1'b0});
          end
        end
        if (res.size() == 0) begin
          res.push_back('{ST_NOTHING, NO_SLOT, '0, 1'b0});
        end
      end
    endcase
    res[res.size()-1].last = 1'b1;
  endfunction

  function automatic dir_row_t row(
    input logic [ACTION_W-1:0] act,
    input logic [SLOT_W-1:0]   slot,
    input logic [HANDLE_W-1:0] handle,
    input logic [DAYS_W-1:0]   days,
    input logic [HMS_W-1:0]    hours, minutes, seconds,
    input logic [MILLIS_W-1:0] millis,
    input logic [TIME_W-1:0]   now,
    input bit                  typed,
    input logic [STATUS_W-1:0] st,
    input logic [SLOT_W-1:0]   so,
    input logic [HANDLE_W-1:0] ho
  );
    dir_row_t d;
    d.req   = '{act, slot, handle, days, hours, minutes, seconds, millis, now};
    d.typed = typed;
    d.exp   = '{st, so, ho, 1'b1};
    return d;
  endfunction

  function automatic request_t random_req();
    request_t r;
    int       pick;
    r    = '0;
    pick = $urandom_range(99);
    if (pick < 30) begin
      r.action = ACT_CREATE;
    end else if (pick < 45) begin
      r.action = ACT_DELETE;
    end else if (pick < 60) begin
      r.action = ACT_SET;
    end else begin
      r.action = ACT_SCAN;
    end
    r.slot = ($urandom_range(9) == 0) ? SLOT_W'($urandom_range(31))
                                      : SLOT_W'($urandom_range(SLOTS - 1));
    r.task_handle = ($urandom_range(9) == 0) ? HANDLE_W'($urandom)
                                             : HANDLE_W'(16'h0A00 + $urandom_range(23));
    if ($urandom_range(7) == 0) begin
      r.delay_days    = DAYS_W'($urandom);
      r.delay_hours   = HMS_W'($urandom);
      r.delay_minutes = HMS_W'($urandom);
      r.delay_seconds = HMS_W'($urandom);
      r.delay_millis  = MILLIS_W'($urandom);
    end else begin
      r.delay_millis = MILLIS_W'($urandom_range(400));
    end
    if ($urandom_range(15) == 0) begin
      sim_now = $urandom;
    end else begin
      sim_now = sim_now + $urandom_range(250);
    end
    r.now_ms = sim_now;
    return r;
  endfunction

  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(6);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
      end
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
    burst_left--;
  endtask

  task automatic send_item(input request_t r, input bit typed, input report_t typed_exp);
    report_t res [$];
    in_ch.valid         <= 1'b1;
    in_ch.action        <= r.action;
    in_ch.slot          <= r.slot;
    in_ch.task_handle   <= r.task_handle;
    in_ch.delay_days    <= r.delay_days;
    in_ch.delay_hours   <= r.delay_hours;
    in_ch.delay_minutes <= r.delay_minutes;
    in_ch.delay_seconds <= r.delay_seconds;
    in_ch.delay_millis  <= r.delay_millis;
    in_ch.now_ms        <= r.now_ms;
    do @(posedge clk); while (!in_ch.ready);
    table_apply(r, res);
    if (typed) begin
      report_q.push_back(typed_exp);
    end else begin
      foreach (res[k]) report_q.push_back(res[k]);
    end
    @(negedge clk);
  endtask

  initial begin
    int       span;
    bit [7:0] mask;
    bit       steady;
    out_ch.ready = 1'b0;
    forever begin
      steady = ($urandom_range(2) == 0);
      mask   = 8'($urandom) | 8'h01;
      span   = $urandom_range(20, 80);
      repeat (span) begin
        @(negedge clk);
        out_ch.ready <= steady | mask[0];
        mask = {mask[0], mask[7:1]};
      end
    end
  end

  always @(posedge clk) begin
    report_t got;
    report_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.status, out_ch.slot_out, out_ch.handle_out, out_ch.last};
      if (report_q.size() == 0) begin
        $error("unexpected result transaction: status %0d slot_out %0d handle_out %0h",
               got.status, got.slot_out, got.handle_out);
        error_count++;
      end else begin
        want = report_q.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          error_count++;
        end
        if (got.slot_out !== want.slot_out) begin
          $error("slot_out: expected %0d, got %0d", want.slot_out, got.slot_out);
          error_count++;
        end
        if (got.handle_out !== want.handle_out) begin
          $error("handle_out: expected %0h, got %0h", want.handle_out, got.handle_out);
          error_count++;
        end
        if (got.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, got.last);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("periodic_task_slot_timer_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    dir_row_t rows [$];
    request_t r;
    int       counted;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.action        = ACT_CREATE;
    in_ch.slot          = '0;
    in_ch.task_handle   = '0;
    in_ch.delay_days    = '0;
    in_ch.delay_hours   = '0;
    in_ch.delay_minutes = '0;
    in_ch.delay_seconds = '0;
    in_ch.delay_millis  = '0;
    in_ch.now_ms        = '0;
    burst_left          = 0;
    sim_now             = '0;
    occ_tab             = '0;
    for (int i = 0; i < SLOTS; i++) begin
      delay_tab[i]  = '0;
      stamp_tab[i]  = '0;
      handle_tab[i] = '0;
    end

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    rows.push_back(row(ACT_SCAN, 0, 0, 0, 0, 0, 0, 0, 0, 1, ST_NOTHING, NO_SLOT, 0));
    rows.push_back(row(ACT_DELETE, 16, 0, 0, 0, 0, 0, 0, 0, 1, ST_INVALID, NO_SLOT, 0));
    rows.push_back(row(ACT_SET, 31, 16'hFFFF, 63, 255, 255, 255, 16'hFFFF, 32'hFFFF_FFFF,
                       1, ST_INVALID, NO_SLOT, 0));
    rows.push_back(row(ACT_DELETE, 0, 0, 0, 0, 0, 0, 0, 0, 1, ST_DONE, 0, 0));
    rows.push_back(row(ACT_SET, 15, 0, 63, 255, 255, 255, 16'hFFFF, 0, 1, ST_DONE, 15, 0));
    rows.push_back(row(ACT_CREATE, 0, 16'hFFFF, 63, 255, 255, 255, 16'hFFFF, 32'hFFFF_FFFF,
                       1, ST_DONE, 0, 16'hFFFF));
    rows.push_back(row(ACT_CREATE, 0, 16'hFFFF, 0, 0, 0, 0, 0, 5, 1, ST_DONE, 0, 16'hFFFF));
    rows.push_back(row(ACT_CREATE, 0, 16'h0001, 0, 0, 0, 0, 0, 100, 1, ST_DONE, 1, 16'h0001));
    rows.push_back(row(ACT_CREATE, 0, 0, 0, 0, 0, 0, 5, 0, 1, ST_DONE, 2, 0));
    rows.push_back(row(ACT_CREATE, 0, 0, 0, 0, 0, 0, 0, 0, 1, ST_DONE, 3, 0));
    rows.push_back(row(ACT_SCAN, 0, 0, 0, 0, 0, 0, 0, 0, 0, ST_DONE, 0, 0));
    rows.push_back(row(ACT_SCAN, 0, 0, 0, 0, 0, 0, 0, 7, 0, ST_DONE, 0, 0));
    rows.push_back(row(ACT_CREATE, 0, 16'h0002, 1, 2, 3, 4, 5, 20, 0, ST_DONE, 0, 0));
    for (int k = 0; k < 11; k++) begin
      rows.push_back(row(ACT_CREATE, 0, HANDLE_W'(16'h0100 + k), 0, 0, 0, 0,
                         MILLIS_W'(10 * k), 30, 0, ST_DONE, 0, 0));
    end
    rows.push_back(row(ACT_CREATE, 0, 16'h0200, 0, 0, 0, 0, 0, 40, 1, ST_FULL, NO_SLOT, 0));
    rows.push_back(row(ACT_DELETE, 2, 0, 0, 0, 0, 0, 0, 0, 1, ST_DONE, 2, 0));
    rows.push_back(row(ACT_CREATE, 0, 16'h0105, 0, 0, 0, 0, 50, 60, 0, ST_DONE, 0, 0));
    rows.push_back(row(ACT_SCAN, 0, 0, 0, 0, 0, 0, 0, 32'h8000_0000, 0, ST_DONE, 0, 0));

    foreach (rows[k]) begin
      pace();
      send_item(rows[k].req, rows[k].typed, rows[k].exp);
    end

    sim_now = 32'h8000_0000;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      r = random_req();
      pace();
      send_item(r, 1'b0, '0);
      if (!((r.action == ACT_DELETE || r.action == ACT_SET) && r.slot >= SLOTS)) begin
        counted++;
      end
    end
    in_ch.valid <= 1'b0;

    while (report_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("periodic_task_slot_timer_tb: PASS");
    end else begin
      $display("periodic_task_slot_timer_tb: FAIL");
    end
    $finish;
  end

endmodule
